// ===== design/tci_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tci_pkg
// Shared widths, codes and controller/datapath interface types for the
// threshold category indexer.
// ----------------------------------------------------------------------------
package tci_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int MAX_PROBES_DEF  = 8;

  localparam int DATA_W      = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int S_TDATA_W   = 64;
  localparam int S_TUSER_W   = 2;
  localparam int M_TDATA_W   = 72;

  localparam logic [DATA_W-1:0] HASH_MULT = 32'h9E37_79B1;

  typedef enum logic [0:0] {
    REQ_LOAD   = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_START_INDEX = 1'b0,
    CFG_MIN_COUNT   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    RES_ZERO   = 2'd0,
    RES_HIT    = 2'd1,
    RES_STORED = 2'd2,
    RES_FULL   = 2'd3
  } res_t;

  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic hash_mul;
    logic mix_mul;
    logic quot_mul;
    logic home_set;
    logic probe_next;
    logic insert;
    logic set_res;
    res_t res;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_probe;
    logic is_load;
    logic slot_free;
    logic slot_match;
    logic probe_last;
    logic out_free;
  } stat_t;

endpackage

// ===== design/tci_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tci_ctrl
// Sequencer: clearing pass, item capture, hash steps, probe loop, insert and
// result hand-off.
// ----------------------------------------------------------------------------
module tci_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  tci_pkg::stat_t stat,
  output tci_pkg::cmd_t  cmd
);
  import tci_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_HASH  = 10'b00_0000_0100,
    S_MIX   = 10'b00_0000_1000,
    S_QMUL  = 10'b00_0001_0000,
    S_HOME  = 10'b00_0010_0000,
    S_RD    = 10'b00_0100_0000,
    S_CMP   = 10'b00_1000_0000,
    S_WR    = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res    = RES_ZERO;
    s_tready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_mul = 1'b1;
        if (stat.need_probe) begin
          state_next = S_MIX;
        end else begin
          cmd.set_res = 1'b1;
          cmd.res     = RES_ZERO;
          state_next  = S_DONE;
        end
      end
      S_MIX: begin
        cmd.mix_mul = 1'b1;
        state_next  = S_QMUL;
      end
      S_QMUL: begin
        cmd.quot_mul = 1'b1;
        state_next   = S_HOME;
      end
      S_HOME: begin
        cmd.home_set = 1'b1;
        state_next   = S_RD;
      end
      S_RD: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (stat.slot_match) begin
          cmd.set_res = 1'b1;
          cmd.res     = RES_HIT;
          state_next  = S_DONE;
        end else if (stat.slot_free) begin
          if (stat.is_load) begin
            state_next = S_WR;
          end else begin
            cmd.set_res = 1'b1;
            cmd.res     = RES_ZERO;
            state_next  = S_DONE;
          end
        end else if (stat.probe_last) begin
          cmd.set_res = 1'b1;
          cmd.res     = stat.is_load ? RES_FULL : RES_ZERO;
          state_next  = S_DONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_RD;
        end
      end
      S_WR: begin
        cmd.insert  = 1'b1;
        cmd.set_res = 1'b1;
        cmd.res     = RES_STORED;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== design/tci_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tci_datapath
// Item and configuration registers, hash arithmetic, slot memory, index
// counter and the output register.
// ----------------------------------------------------------------------------
module tci_datapath #(
  parameter int TABLE_DEPTH = tci_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_PROBES  = tci_pkg::MAX_PROBES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tci_pkg::cmd_t                    cmd,
  output tci_pkg::stat_t                   stat,
  input  logic [tci_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic [tci_pkg::S_TUSER_W-1:0]    s_tuser,
  input  logic                             cfg_valid,
  input  logic [tci_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tci_pkg::DATA_W-1:0]       cfg_data,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [tci_pkg::M_TDATA_W-1:0]    m_tdata
);
  import tci_pkg::*;

  localparam int SLOT_W  = $clog2(TABLE_DEPTH);
  localparam int PCNT_W  = $clog2(MAX_PROBES + 1);
  localparam int MEM_W   = 1 + 2 * DATA_W;
  localparam int SHIFT   = DATA_W + SLOT_W;
  localparam int RECIP_W = DATA_W + 1;
  localparam int PROD_W  = DATA_W + RECIP_W;
  localparam int PAD_W   = M_TDATA_W - (3 * 1 + 2 * DATA_W);
  // Reciprocal of the table depth; the estimated quotient is low by at most one.
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << SHIFT) / TABLE_DEPTH);
  localparam logic [DATA_W-1:0] DEPTH_C = DATA_W'(TABLE_DEPTH);

  // Configuration and counter; writing the start index loads the counter.
  logic [DATA_W-1:0] min_count;
  logic [DATA_W-1:0] counter;

  // Captured item
  logic              is_load;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] occ_q;
  logic              present_q;

  // Hash pipeline registers
  logic [DATA_W-1:0] hprod;
  logic [DATA_W-1:0] hmix;
  logic [PROD_W-1:0] qprod;
  logic [DATA_W-1:0] qd;
  logic [DATA_W-1:0] hmix_w;
  logic [DATA_W-1:0] quot;
  logic [DATA_W-1:0] rem_raw;
  logic [DATA_W-1:0] rem;

  // Probe state
  logic [SLOT_W-1:0] slot;
  logic [PCNT_W-1:0] probe_cnt;
  logic [SLOT_W-1:0] clr_addr;

  // Slot memory: {valid, key, index}
  logic [MEM_W-1:0]  mem [TABLE_DEPTH];
  logic [MEM_W-1:0]  rdata;
  logic              rd_valid;
  logic [DATA_W-1:0] rd_key;
  logic [DATA_W-1:0] rd_index;

  // Result
  res_t              res_q;
  logic [DATA_W-1:0] found_idx;
  logic [DATA_W-1:0] out_index;
  logic              out_hit;
  logic              out_stored;
  logic              out_full;
  logic [DATA_W-1:0] out_next;
  logic [DATA_W-1:0] counter_next;
  logic [DATA_W-1:0] index_next;

  assign hmix_w  = hprod ^ (hprod >> 16);
  assign quot    = DATA_W'(qprod >> SHIFT);
  assign rem_raw = hmix - qd;
  assign rem     = (rem_raw >= DEPTH_C) ? (rem_raw - DEPTH_C) : rem_raw;

  assign rd_valid = rdata[MEM_W-1];
  assign rd_key   = rdata[DATA_W +: DATA_W];
  assign rd_index = rdata[DATA_W-1:0];

  assign stat.clear_last = (clr_addr == SLOT_W'(TABLE_DEPTH - 1));
  assign stat.need_probe = is_load ? (occ_q >= min_count) : present_q;
  assign stat.is_load    = is_load;
  assign stat.slot_free  = !rd_valid;
  assign stat.slot_match = rd_valid && (rd_key == key_q);
  assign stat.probe_last = (probe_cnt == PCNT_W'(MAX_PROBES - 1));
  assign stat.out_free   = !m_tvalid || m_tready;

  // An admitted load advances the counter whatever the probe outcome.
  assign counter_next = (is_load && stat.need_probe) ? (counter + 1'b1) : counter;

  always_comb begin
    case (res_q)
      RES_HIT:    index_next = found_idx;
      RES_STORED: index_next = counter;
      RES_FULL:   index_next = '0;
      RES_ZERO:   index_next = '0;
      default:    index_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_count   <= DATA_W'(1);
      counter     <= DATA_W'(1);
      clr_addr    <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cmd.clear_wr) clr_addr <= clr_addr + 1'b1;
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
        counter  <= counter_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          CFG_START_INDEX: counter <= cfg_data;
          CFG_MIN_COUNT: min_count <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_load   <= (req_t'(s_tuser[0]) == REQ_LOAD);
      present_q <= s_tuser[1];
      key_q     <= s_tdata[DATA_W-1:0];
      occ_q     <= s_tdata[2*DATA_W-1:DATA_W];
    end
    if (cmd.hash_mul) hprod <= DATA_W'(key_q * HASH_MULT);
    if (cmd.mix_mul) begin
      hmix  <= hmix_w;
      qprod <= PROD_W'(hmix_w) * PROD_W'(RECIP);
    end
    if (cmd.quot_mul) qd <= DATA_W'(quot * DEPTH_C);
    if (cmd.home_set) begin
      slot      <= rem[SLOT_W-1:0];
      probe_cnt <= '0;
    end else if (cmd.probe_next) begin
      slot      <= (slot == SLOT_W'(TABLE_DEPTH - 1)) ? '0 : slot + 1'b1;
      probe_cnt <= probe_cnt + 1'b1;
    end
    if (cmd.set_res) begin
      res_q     <= cmd.res;
      found_idx <= rd_index;
    end
    if (cmd.finish) begin
      out_index  <= index_next;
      out_hit    <= (res_q == RES_HIT);
      out_stored <= (res_q == RES_STORED);
      out_full   <= (res_q == RES_FULL);
      out_next   <= counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      mem[clr_addr] <= '0;
    end else if (cmd.insert) begin
      mem[slot] <= {1'b1, key_q, counter};
    end
    rdata <= mem[slot];
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_next, out_full, out_stored, out_hit, out_index};

endmodule

// ===== design/threshold_category_indexer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_category_indexer_top
// Hash dictionary from category keys to dense indices with threshold admission.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the s_ stream (tuser carries the request kind and the
// record-present flag, tdata the key and the occurrence count). Each item
// gives exactly one result item on the m_ stream. Registers are written on
// the cfg channel, which is always ready; write it only while the block idles.
// After reset the block runs a clearing pass over all TABLE_DEPTH slots of
// the slot memory (4096 by default) with s_tready low, then accepts items.
// One item is worked on at a time. A load below the threshold or an empty
// lookup ends after the hash multiply. A probed item goes through the hash
// steps (multiply, mix and reciprocal multiply, quotient multiply, home
// slot), then a registered read of the single-port slot memory and a
// compare for each slot visited (1 to MAX_PROBES), plus a write step when
// a new entry is stored.
// The result sits in an output register; the next item is accepted while it
// waits, and a stalled receiver holds the block only when a second result is
// ready to be written.
// ----------------------------------------------------------------------------
module threshold_category_indexer_top #(
  parameter int TABLE_DEPTH = tci_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_PROBES  = tci_pkg::MAX_PROBES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [tci_pkg::S_TDATA_W-1:0]    s_tdata,   // key, occurrences
  input  logic [tci_pkg::S_TUSER_W-1:0]    s_tuser,   // req_type, key_present
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // index, hit, stored, table_full, next_index, zero padding
  output logic [tci_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tci_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tci_pkg::DATA_W-1:0]       cfg_data
);
  import tci_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  tci_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tci_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_PROBES  (MAX_PROBES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== design/tci_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tci_checker
// Port-level checks on the indexer, bound to the top level.
// ----------------------------------------------------------------------------
module tci_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [tci_pkg::M_TDATA_W-1:0]    m_tdata
);
  import tci_pkg::*;

  logic res_hit, res_stored, res_full;

  assign res_hit    = m_tdata[DATA_W];
  assign res_stored = m_tdata[DATA_W+1];
  assign res_full   = m_tdata[DATA_W+2];

  // Reset starts the clearing pass with no result pending.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!s_tready && !m_tvalid))
    else $error("block not quiet after reset");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // At most one of hit, stored and table_full is set.
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0({res_hit, res_stored, res_full}))
    else $error("result flags not exclusive");

  // Without a hit or a new entry the index reads zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !res_hit && !res_stored) |-> (m_tdata[DATA_W-1:0] == '0))
    else $error("nonzero index on miss");

  // One item at a time: acceptance drops ready on the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item accepted while busy");

endmodule

bind threshold_category_indexer_top tci_checker u_tci_checker (.*);
